[rtl/core/sorted_list_insert_search_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list block
// Clocked on clk_i, muted while rst_ni is low; report by $error.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_SEARCH_ASSERT_SVH
`define SORTED_LIST_INSERT_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define SLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted list: same-cycle check failed");

// Next-cycle implication.
`define SLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list: next-cycle check failed");

`endif

[rtl/core/sls_pkg.sv]
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types and constants of the sorted list insert and search block.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_OUT_W  = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Broadcast control seen by every cell of the chain.
  typedef struct packed {
    logic insert_en;   // shift / load this cycle
    logic descending;  // ordering rule
  } cell_ctrl_t;

endpackage

[rtl/core/sls_cell.sv]
// ----------------------------------------------------------------------------
// sls_cell
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast value, and loads either the value or its front neighbor's entry.
// ----------------------------------------------------------------------------
module sls_cell (
  input  logic                              clk_i,
  input  sls_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [sls_pkg::DATA_W-1:0] value_i,
  input  logic                              valid_i,
  input  logic signed [sls_pkg::DATA_W-1:0] prev_entry_i,
  input  logic                              placed_i,
  output logic signed [sls_pkg::DATA_W-1:0] entry_o,
  output logic                              placed_o,
  output logic                              hit_o
);

  logic signed [sls_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                              pass;

  // An entry lets the value go further back while it sorts strictly ahead.
  assign pass = valid_i && (ctrl_i.descending ? (entry_q > value_i)
                                              : (entry_q < value_i));

  assign placed_o = placed_i | ~pass;
  assign hit_o    = valid_i && (entry_q == value_i);
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert_en) begin
      if (placed_i) begin
        entry_d = prev_entry_i;   // slot opened in front: move back
      end else if (!pass) begin
        entry_d = value_i;        // first slot that fails the rule
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[rtl/core/sorted_list_insert_search.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_search
// Bounded sorted list of signed 32-bit values held in a chain of cells,
// with insert and membership search.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  --------  -------------------------  ---------------------------------
//  command   start / busy               mode_i, value_i
//  result    done_o (one-cycle strobe)  status_o, entry_count_o
//  config    cfg_valid_i / cfg_ready_o  descending_order_i
//
//  One command per cycle: every cell compares against the broadcast value in
//  parallel and moves at most one place, so a transaction accepted at one
//  edge shows its result with done_o during the following cycle.
//  busy stays low; the result register frees the command side at once.
//  Reset clears the entry count, the order bit and the result strobe; cell
//  contents are not cleared, entries past the count are never looked at.
//  The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_search_assert.svh"

module sorted_list_insert_search #(
  parameter int unsigned CAPACITY = sls_pkg::CAPACITY_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command transaction
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode_i,
  input  logic signed [sls_pkg::DATA_W-1:0]      value_i,
  // result transaction
  output logic                                   done_o,
  output logic [1:0]                             status_o,
  output logic [sls_pkg::COUNT_OUT_W-1:0]        entry_count_o,
  // configuration transaction
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic                                   descending_order_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  logic [CntW-1:0]      count_q, count_d;
  logic                 desc_q, desc_d;
  logic                 done_q, done_d;
  sls_pkg::status_e     status_q, status_d;

  logic                 accept;
  logic                 is_search;
  logic                 full;
  sls_pkg::cell_ctrl_t  ctrl;

  // Commands are always taken; the config bit is always writable.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign accept    = start && !busy;
  assign is_search = (mode_i == sls_pkg::OP_SEARCH);
  assign full      = (count_q == CntW'(CAPACITY));

  assign ctrl.insert_en  = accept && !is_search && !full;
  assign ctrl.descending = desc_q;

  // --------------------------------------------------------------------------
  // Cell chain: the placed flag ripples from the front; once some cell has
  // taken the value, every cell behind it takes its front neighbor's entry.
  // --------------------------------------------------------------------------
  logic signed [sls_pkg::DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY:0]                 placed;
  logic [CAPACITY-1:0]               hits;

  assign placed[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sls_pkg::DATA_W-1:0] prev_entry;
    logic                              cell_valid;

    // Valid slots form a prefix of the chain, set by the count.
    assign cell_valid = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_entry = value_i;   // never used: nothing sits in front
    end else begin : g_body
      assign prev_entry = entries[i-1];
    end

    sls_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .value_i      (value_i),
      .valid_i      (cell_valid),
      .prev_entry_i (prev_entry),
      .placed_i     (placed[i]),
      .entry_o      (entries[i]),
      .placed_o     (placed[i+1]),
      .hit_o        (hits[i])
    );
  end

  // --------------------------------------------------------------------------
  // Next state and result
  // --------------------------------------------------------------------------
  always_comb begin
    count_d  = count_q;
    desc_d   = desc_q;
    done_d   = accept;
    status_d = status_q;

    if (cfg_valid_i && cfg_ready_o) begin
      desc_d = descending_order_i;
    end

    if (accept) begin
      if (is_search) begin
        status_d = (|hits) ? sls_pkg::ST_FOUND : sls_pkg::ST_NOT_FOUND;
      end else if (full) begin
        status_d = sls_pkg::ST_FULL;      // drop the insert, keep the count
      end else begin
        status_d = sls_pkg::ST_INSERTED;
        count_d  = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      desc_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      desc_q  <= desc_d;
      done_q  <= done_d;
    end
  end

  // Result payload: no reset, qualified by done_o.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  // Count goes out as its low bits, zero-extended when narrower.
  logic [CntW+sls_pkg::COUNT_OUT_W-1:0] count_ext;
  assign count_ext = {{sls_pkg::COUNT_OUT_W{1'b0}}, count_q};

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[sls_pkg::COUNT_OUT_W-1:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SLS_ASSERT_NEXT(a_done_follows_cmd, accept, done_o)
  `SLS_ASSERT_NEXT(a_no_spurious_done, !accept, !done_o)
  `SLS_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CntW'(CAPACITY))
  `SLS_ASSERT_NEXT(a_insert_grows,
                   ctrl.insert_en,
                   (count_q == CntW'($past(count_q) + 1'b1)) &&
                   (status_o == sls_pkg::ST_INSERTED))
  `SLS_ASSERT_NEXT(a_full_drops,
                   accept && !is_search && full,
                   (count_q == $past(count_q)) && (status_o == sls_pkg::ST_FULL))

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for sorted_list_insert_search
// Drives insert and search commands in random bursts, flips the list order
// between phases while the block is idle, and checks every status and entry
// count against a scoreboard that keeps its own copy of the sorted list.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sls_pkg::*;

  localparam int unsigned LIST_DEPTH    = CAPACITY_DEF;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 135;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PRINT_LIMIT   = 100;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    status_e                status;
    logic [COUNT_OUT_W-1:0] count;
  } list_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the list, the order bit and the queue of
  // results still owed by the block.
  // --------------------------------------------------------------------------
  class sorted_list_scoreboard;
    logic signed [DATA_W-1:0] entries [LIST_DEPTH];
    int unsigned              held;
    bit                       descending;
    list_result_t             owed[$];
    int unsigned              mismatches;
    int unsigned              status_seen [4];

    function new();
      held       = 0;
      descending = 1'b0;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_order(bit desc);
      descending = desc;
    endfunction

    // Work out the result of one accepted command and update the list copy.
    function void note_command(op_e op, logic signed [DATA_W-1:0] v);
      list_result_t r;
      int unsigned  pos;
      if (op == OP_SEARCH) begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < held; i++) begin
          if (entries[i] == v) r.status = ST_FOUND;
        end
      end else if (held >= LIST_DEPTH) begin
        // full: drop the value, keep the count
        r.status = ST_FULL;
      end else begin
        // walk past entries that still satisfy the current order rule
        pos = 0;
        while (pos < held && (descending ? entries[pos] > v : entries[pos] < v)) pos++;
        for (int i = held; i > pos; i--) entries[i] = entries[i-1];
        entries[pos] = v;
        held++;
        r.status = ST_INSERTED;
      end
      r.count = COUNT_OUT_W'(held);
      owed.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Compare one result from the block with the oldest owed result.
    task check_result(logic [1:0] st, logic [COUNT_OUT_W-1:0] cnt);
      list_result_t r;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed: status=%0d count=%0d", st, cnt));
        return;
      end
      r = owed.pop_front();
      status_seen[r.status]++;
      if (st !== r.status)
        report($sformatf("status %0d, expected %s", st, r.status.name()));
      if (cnt !== r.count)
        report($sformatf("entry count %0d, expected %0d", cnt, r.count));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     mode_i = 1'b0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     done_o;
  logic [1:0]               status_o;
  logic [COUNT_OUT_W-1:0]   entry_count_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic                     descending_order_i = 1'b0;

  always #5 clk_i = ~clk_i;

  sorted_list_insert_search #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .mode_i            (mode_i),
    .value_i           (value_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .entry_count_o     (entry_count_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .descending_order_i(descending_order_i)
  );

  sorted_list_scoreboard sb = new();

  int unsigned inserts_sent;
  int unsigned searches_sent;
  int unsigned order_writes;
  int unsigned burst_left;
  int unsigned stall_cycles;

  // --------------------------------------------------------------------------
  // Monitor: every input read here is the value before the edge, so the
  // nonblocking drives below never race with it. Note the command first, in
  // case the block answers within the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_order(descending_order_i);
      if (start && !busy) sb.note_command(op_e'(mode_i), value_i);
      if (done_o) sb.check_result(status_o, entry_count_o);
    end
  end

  // Watchdog: end the run when no transaction of any kind moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sorted_list_insert_search: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Hold start low for the requested number of cycles and put noise on the idle payload.
  task automatic idle_gap(int unsigned cycles);
    repeat (cycles) begin
      start   <= 1'b0;
      mode_i  <= $urandom_range(0, 1);
      value_i <= $urandom;
      @(posedge clk_i);
    end
  endtask

  // Send one command; return at the edge that accepted it.
  task automatic issue(op_e op, logic signed [DATA_W-1:0] v);
    // end of a burst: maybe pause, then draw the next burst length
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start  <= 1'b1;
    mode_i <= op;
    value_i <= v;
    if (op == OP_INSERT) inserts_sent++;
    else searches_sent++;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write the order bit while the block is idle.
  task automatic write_order(bit desc);
    drain();
    cfg_valid_i        <= 1'b1;
    descending_order_i <= desc;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i        <= 1'b0;
    descending_order_i <= $urandom_range(0, 1);
    order_writes++;
  endtask

  // Mix of extremes, a narrow band around zero for ties, held values, and
  // full-width random values.
  function automatic logic signed [DATA_W-1:0] pick_value(bit prefer_held);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (prefer_held && sb.held != 0 && $urandom_range(0, 4) != 0)
      return sb.entries[$urandom_range(0, sb.held - 1)];
    case (sel)
      0: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      1, 2, 3: return $signed(DATA_W'($urandom_range(0, 8))) - 4;
      4, 5: begin
        if (sb.held != 0) return sb.entries[$urandom_range(0, sb.held - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    inserts_sent  = 0;
    searches_sent = 0;
    order_writes  = 0;
    burst_left    = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extremes, duplicates, ascending then descending.
    write_order(1'b0);
    issue(OP_SEARCH, 32'sd0);
    issue(OP_SEARCH, VAL_MIN);
    issue(OP_INSERT, 32'sd5);
    issue(OP_INSERT, VAL_MAX);
    issue(OP_INSERT, VAL_MIN);
    issue(OP_INSERT, 32'sd5);
    issue(OP_INSERT, -32'sd1);
    issue(OP_SEARCH, 32'sd5);
    issue(OP_SEARCH, VAL_MAX);
    issue(OP_SEARCH, VAL_MIN);
    issue(OP_SEARCH, 32'sd4);
    issue(OP_SEARCH, 32'sh5555_5555);
    // flip order with entries held: stored entries stay where they are
    write_order(1'b1);
    issue(OP_INSERT, 32'sd0);
    issue(OP_INSERT, VAL_MAX);
    issue(OP_INSERT, VAL_MIN);
    issue(OP_INSERT, 32'sd5);
    issue(OP_SEARCH, 32'sd0);
    issue(OP_SEARCH, 32'sd6);
    write_order(1'b0);
    issue(OP_INSERT, 32'sd3);
    issue(OP_SEARCH, -32'sd1);
    issue(OP_SEARCH, 32'shaaaa_aaaa);

    // Random phases: inserts are sparse so the list fills late; the last
    // phase leans on inserts to reach and hammer the full list.
    for (int p = 0; p < PHASES; p++) begin
      write_order((p % 2 == 1) ^ ($urandom_range(0, 3) == 0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == PHASES - 1) ? $urandom_range(0, 1) == 0 : $urandom_range(0, 15) == 0)
          issue(OP_INSERT, pick_value(1'b0));
        else
          issue(OP_SEARCH, pick_value(1'b1));
        // pause once mid-phase until every owed result is in
        if (n == PHASE_ITEMS / 2 && p == 2) drain();
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d results never came", sb.owed.size()));

    $display("Run covered %0d inserts and %0d searches over %0d order writes, ending with %0d held.",
             inserts_sent, searches_sent, order_writes, sb.held);
    $display("Statuses checked: inserted %0d, found %0d, not found %0d, full %0d; %0d errors.",
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_FOUND],
             sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("sorted_list_insert_search: match");
    end else begin
      $display("sorted_list_insert_search: mismatch");
    end
    $finish;
  end

endmodule
